### rtl/core/flas_pkg.sv
package flas_pkg;

    // Widths fixed by the interface
    localparam int TIMEOUT_BITS = 16;
    localparam int DEF_AGE_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd50;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CMD_TIMEOUT  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAT_TIMEOUT = 1'b1;

    // Input word kinds
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_ARM    = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_CMD    = 2'd3
    } action_t;

    // Command modes
    localparam logic [1:0] CMD_OTHER = 2'd0;
    localparam logic [1:0] CMD_ATT   = 2'd1;
    localparam logic [1:0] CMD_RATE  = 2'd2;

    // Bridge mode codes on the result word
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;

    // Feedback codes
    localparam logic [1:0] FB_NONE   = 2'd0;
    localparam logic [1:0] FB_MANUAL = 2'd1;
    localparam logic [1:0] FB_ATT    = 2'd2;
    localparam logic [1:0] FB_RATE   = 2'd3;

    // Refusal codes
    localparam logic [1:0] REF_NONE        = 2'd0;
    localparam logic [1:0] REF_CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] REF_LINK        = 2'd2;
    localparam logic [1:0] REF_LOCKED      = 2'd3;

    // Setpoint kinds
    localparam logic [1:0] KIND_ZERO    = 2'd0;
    localparam logic [1:0] KIND_RATE    = 2'd1;
    localparam logic [1:0] KIND_ATT     = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    // Supervisor state, one-hot
    typedef enum logic [2:0] {
        ST_OFF    = 3'b001,
        ST_AUTO   = 3'b010,
        ST_MANUAL = 3'b100
    } bridge_state_t;

    // One input word
    typedef struct packed {
        action_t    action;
        logic       arm_on;
        logic       status_offboard;
        logic       status_connected;
        logic       status_armed;
        logic       cmd_armed;
        logic [1:0] cmd_mode;
    } item_t;

    // One result word
    typedef struct packed {
        logic [1:0] bridge_mode;
        logic [1:0] feedback_mode;
        logic [1:0] refusal;
        logic       setpoint_sent;
        logic [1:0] setpoint_kind;
        logic       arm_controller;
    } result_t;

    // Map the one-hot state onto its external code
    function automatic logic [1:0] mode_code(input bridge_state_t st);
        logic [1:0] code;
        case (st)
            ST_AUTO:   code = MODE_AUTO;
            ST_MANUAL: code = MODE_MANUAL;
            default:   code = MODE_OFF;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/flas_in_reg.sv
module flas_in_reg
    import flas_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept a new word when empty or when the held word is consumed
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/flas_core.sv
module flas_core
    import flas_pkg::*;
#(
    parameter int AGE_BITS = DEF_AGE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIMEOUT_BITS-1:0]   cfg_wdata,
    input  logic                      step_en,
    input  item_t                     item,
    output result_t                   result
);

    localparam int CW = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic [TIMEOUT_BITS-1:0] cmd_to_reg;
    logic [TIMEOUT_BITS-1:0] stat_to_reg;

    bridge_state_t        state_reg, state_next;
    logic [1:0]           cmd_mode_reg, cmd_mode_next;
    logic [AGE_BITS-1:0]  cmd_age_reg, cmd_age_next;
    logic [AGE_BITS-1:0]  stat_age_reg, stat_age_next;
    logic                 link_reg, link_next;
    logic                 ctl_armed_reg, ctl_armed_next;
    logic                 ctl_offb_reg, ctl_offb_next;

    logic [AGE_BITS-1:0]  cmd_age_inc;
    logic [AGE_BITS-1:0]  stat_age_inc;
    logic [CW-1:0]        cmd_to_ext;
    logic [CW-1:0]        stat_to_ext;
    logic                 stale_now;
    logic                 bad_now;
    logic                 stale_tick;
    logic                 bad_tick;

    // Timeout registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_to_reg  <= TIMEOUT_RESET;
            stat_to_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CMD_TIMEOUT:  cmd_to_reg  <= cfg_wdata;
                REG_STAT_TIMEOUT: stat_to_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturating age bumps and timeout compares
    assign cmd_age_inc  = (cmd_age_reg == AGE_MAX) ? AGE_MAX : cmd_age_reg + 1'b1;
    assign stat_age_inc = (stat_age_reg == AGE_MAX) ? AGE_MAX : stat_age_reg + 1'b1;
    assign cmd_to_ext   = CW'(cmd_to_reg);
    assign stat_to_ext  = CW'(stat_to_reg);
    assign stale_now    = CW'(cmd_age_reg) > cmd_to_ext;
    assign bad_now      = (CW'(stat_age_reg) > stat_to_ext) || !link_reg;
    assign stale_tick   = CW'(cmd_age_inc) > cmd_to_ext;
    assign bad_tick     = (CW'(stat_age_inc) > stat_to_ext) || !link_reg;

    // Step logic for one word
    always_comb begin
        state_next     = state_reg;
        cmd_mode_next  = cmd_mode_reg;
        cmd_age_next   = cmd_age_reg;
        stat_age_next  = stat_age_reg;
        link_next      = link_reg;
        ctl_armed_next = ctl_armed_reg;
        ctl_offb_next  = ctl_offb_reg;
        result         = '0;

        case (item.action)
            ACT_TICK: begin
                cmd_age_next  = cmd_age_inc;
                stat_age_next = stat_age_inc;
                if (state_reg == ST_AUTO && (stale_tick || bad_tick)) begin
                    state_next = ST_OFF;
                end
            end
            ACT_ARM: begin
                if (!item.arm_on) begin
                    state_next = ST_OFF;
                end else if (stale_now) begin
                    result.refusal = REF_CMD_TIMEOUT;
                end else if (bad_now) begin
                    result.refusal = REF_LINK;
                end else begin
                    state_next = ST_AUTO;
                end
            end
            ACT_STATUS: begin
                ctl_offb_next  = item.status_offboard;
                link_next      = item.status_connected;
                ctl_armed_next = item.status_armed;
                stat_age_next  = '0;
                if (!item.status_offboard && state_reg == ST_AUTO) begin
                    state_next = ST_MANUAL;
                end else if (item.status_offboard && state_reg == ST_MANUAL) begin
                    state_next = ST_AUTO;
                end
            end
            default: begin
                cmd_age_next = '0;
                if (state_reg == ST_OFF) begin
                    if (item.cmd_armed) begin
                        result.refusal = REF_LOCKED;
                    end
                end else begin
                    result.arm_controller = item.cmd_armed && state_reg == ST_AUTO
                                            && !ctl_armed_reg;
                    result.setpoint_sent = 1'b1;
                    if (!item.cmd_armed) begin
                        result.setpoint_kind = KIND_ZERO;
                    end else if (item.cmd_mode == CMD_RATE) begin
                        result.setpoint_kind = KIND_RATE;
                    end else if (item.cmd_mode == CMD_ATT) begin
                        result.setpoint_kind = KIND_ATT;
                    end else begin
                        result.setpoint_kind = KIND_INVALID;
                    end
                    cmd_mode_next = (item.cmd_mode == CMD_ATT || item.cmd_mode == CMD_RATE)
                                    ? item.cmd_mode : CMD_OTHER;
                end
            end
        endcase

        // Report state and feedback after the update
        result.bridge_mode = mode_code(state_next);
        case (state_next)
            ST_MANUAL: result.feedback_mode = FB_MANUAL;
            ST_AUTO: begin
                if (cmd_mode_next == CMD_ATT) begin
                    result.feedback_mode = FB_ATT;
                end else if (cmd_mode_next == CMD_RATE) begin
                    result.feedback_mode = FB_RATE;
                end else begin
                    result.feedback_mode = FB_NONE;
                end
            end
            default: result.feedback_mode = FB_NONE;
        endcase
    end

    // Commit state only when a word is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_OFF;
            cmd_mode_reg  <= CMD_OTHER;
            cmd_age_reg   <= AGE_MAX;
            stat_age_reg  <= AGE_MAX;
            link_reg      <= 1'b0;
            ctl_armed_reg <= 1'b0;
            ctl_offb_reg  <= 1'b0;
        end else if (step_en) begin
            state_reg     <= state_next;
            cmd_mode_reg  <= cmd_mode_next;
            cmd_age_reg   <= cmd_age_next;
            stat_age_reg  <= stat_age_next;
            link_reg      <= link_next;
            ctl_armed_reg <= ctl_armed_next;
            ctl_offb_reg  <= ctl_offb_next;
        end
    end

endmodule

### rtl/core/flight_link_arming_supervisor.sv
// An accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle, set by the input register and the result register
// both moving together whenever the result side takes or is empty.
// Reset (aresetn low, synchronous): state off, command mode none, both ages saturated,
// link and controller flags clear, both timeouts 50, no words held.
module flight_link_arming_supervisor
    import flas_pkg::*;
#(
    parameter int AGE_BITS = DEF_AGE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration writes
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIMEOUT_BITS-1:0]   cfg_wdata,
    // Input words
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,  // arm_on, status_offboard,
                                                // status_connected, status_armed,
                                                // cmd_armed, cmd_mode[1:0], pad
    input  logic [1:0]                s_tuser,  // action[1:0]
    // Result words
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata   // bridge_mode[1:0], feedback_mode[1:0],
                                                // refusal[1:0], setpoint_sent,
                                                // setpoint_kind[1:0], arm_controller, pad
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t result;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    // Unpack the input word
    assign in_item.action           = action_t'(s_tuser);
    assign in_item.arm_on           = s_tdata[0];
    assign in_item.status_offboard  = s_tdata[1];
    assign in_item.status_connected = s_tdata[2];
    assign in_item.status_armed     = s_tdata[3];
    assign in_item.cmd_armed        = s_tdata[4];
    assign in_item.cmd_mode         = s_tdata[6:5];

    // Consume the held word when the result register can load
    assign take = item_valid && (!out_valid_reg || m_tready);

    flas_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    flas_core #(
        .AGE_BITS (AGE_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step_en   (take),
        .item      (item),
        .result    (result)
    );

    // Result register
    assign out_valid_next = take ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= result;
        end
    end

    // Pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_reg.arm_controller,
                       out_reg.setpoint_kind,
                       out_reg.setpoint_sent,
                       out_reg.refusal,
                       out_reg.feedback_mode,
                       out_reg.bridge_mode};

endmodule

### tb/tb_flight_link_arming_supervisor.sv
module tb_flight_link_arming_supervisor;
    import flas_pkg::*;

    localparam logic [15:0] AGE_SAT = 16'hFFFF;
    localparam int RANDOM_PER_PHASE = 118;
    localparam int LONG_HOLD_CYCLES = 100;

    // Clock, reset and block ports
    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [TIMEOUT_BITS-1:0]   cfg_wdata = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;  // arm_on, status_offboard, status_connected,
                                              // status_armed, cmd_armed, cmd_mode[1:0], pad
    logic [1:0]                s_tuser = '0;  // action[1:0]
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [15:0]               m_tdata;       // bridge_mode[1:0], feedback_mode[1:0],
                                              // refusal[1:0], setpoint_sent,
                                              // setpoint_kind[1:0], arm_controller, pad

    always #4 aclk = ~aclk;

    flight_link_arming_supervisor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Supervisor shadow state
    logic [1:0]  sup_mode;
    logic [1:0]  sup_cmd_mode;
    logic [15:0] cmd_age;
    logic [15:0] stat_age;
    logic        link_up;
    logic        fc_armed;
    logic        fc_offboard;
    logic [15:0] cmd_limit;
    logic [15:0] stat_limit;

    result_t pending_results[$];
    int      errors = 0;
    int      checked = 0;

    typedef struct {
        item_t   word;
        logic    fixed;
        result_t want;
    } row_t;

    row_t plan[$];

    function automatic item_t make_word(input action_t a, input logic arm, input logic offb,
                                        input logic conn, input logic armd, input logic carm,
                                        input logic [1:0] cm);
        item_t w;
        w.action           = a;
        w.arm_on           = arm;
        w.status_offboard  = offb;
        w.status_connected = conn;
        w.status_armed     = armd;
        w.cmd_armed        = carm;
        w.cmd_mode         = cm;
        return w;
    endfunction

    function automatic result_t make_result(input logic [1:0] mode, input logic [1:0] fb,
                                            input logic [1:0] rf, input logic sent,
                                            input logic [1:0] kind, input logic armc);
        result_t r;
        r.bridge_mode    = mode;
        r.feedback_mode  = fb;
        r.refusal        = rf;
        r.setpoint_sent  = sent;
        r.setpoint_kind  = kind;
        r.arm_controller = armc;
        return r;
    endfunction

    // Advance the shadow supervisor by one word and return its result
    function automatic result_t supervise(input item_t w);
        result_t r;
        r = '0;
        case (w.action)
            ACT_TICK: begin
                if (cmd_age != AGE_SAT) cmd_age = cmd_age + 16'd1;
                if (stat_age != AGE_SAT) stat_age = stat_age + 16'd1;
                if (sup_mode == MODE_AUTO &&
                    (cmd_age > cmd_limit || stat_age > stat_limit || !link_up))
                    sup_mode = MODE_OFF;
            end
            ACT_ARM: begin
                if (!w.arm_on)
                    sup_mode = MODE_OFF;
                else if (cmd_age > cmd_limit)
                    r.refusal = REF_CMD_TIMEOUT;
                else if (stat_age > stat_limit || !link_up)
                    r.refusal = REF_LINK;
                else
                    sup_mode = MODE_AUTO;
            end
            ACT_STATUS: begin
                fc_offboard = w.status_offboard;
                link_up     = w.status_connected;
                fc_armed    = w.status_armed;
                stat_age    = '0;
                if (!w.status_offboard && sup_mode == MODE_AUTO)
                    sup_mode = MODE_MANUAL;
                else if (w.status_offboard && sup_mode == MODE_MANUAL)
                    sup_mode = MODE_AUTO;
            end
            default: begin
                cmd_age = '0;
                if (sup_mode == MODE_OFF) begin
                    if (w.cmd_armed) r.refusal = REF_LOCKED;
                end else begin
                    r.arm_controller = w.cmd_armed && sup_mode == MODE_AUTO && !fc_armed;
                    r.setpoint_sent  = 1'b1;
                    if (!w.cmd_armed)
                        r.setpoint_kind = KIND_ZERO;
                    else if (w.cmd_mode == CMD_RATE)
                        r.setpoint_kind = KIND_RATE;
                    else if (w.cmd_mode == CMD_ATT)
                        r.setpoint_kind = KIND_ATT;
                    else
                        r.setpoint_kind = KIND_INVALID;
                    sup_cmd_mode = (w.cmd_mode == CMD_ATT || w.cmd_mode == CMD_RATE) ?
                                   w.cmd_mode : CMD_OTHER;
                end
            end
        endcase
        r.bridge_mode = sup_mode;
        if (sup_mode == MODE_MANUAL)
            r.feedback_mode = FB_MANUAL;
        else if (sup_mode == MODE_AUTO)
            r.feedback_mode = (sup_cmd_mode == CMD_ATT)  ? FB_ATT :
                              (sup_cmd_mode == CMD_RATE) ? FB_RATE : FB_NONE;
        else
            r.feedback_mode = FB_NONE;
        return r;
    endfunction

    // Mostly plausible traffic, the rest fully random noise
    function automatic item_t random_word();
        item_t w;
        int    pick;
        w.action           = action_t'(2'($urandom_range(0, 3)));
        w.arm_on           = 1'($urandom);
        w.status_offboard  = 1'($urandom);
        w.status_connected = 1'($urandom);
        w.status_armed     = 1'($urandom);
        w.cmd_armed        = 1'($urandom);
        w.cmd_mode         = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                w.action = ACT_TICK;
            else if (pick < 50)
                w.action = ACT_ARM;
            else if (pick < 70)
                w.action = ACT_STATUS;
            else
                w.action = ACT_CMD;
            w.arm_on           = ($urandom_range(0, 6) != 0);
            w.status_offboard  = ($urandom_range(0, 4) != 0);
            w.status_connected = ($urandom_range(0, 9) != 0);
            w.cmd_armed        = ($urandom_range(0, 3) != 0);
        end
        return w;
    endfunction

    task automatic add_row(input item_t w, input logic fixed, input result_t want);
        row_t r;
        r.word  = w;
        r.fixed = fixed;
        r.want  = want;
        plan.push_back(r);
    endtask

    // Offer one word from a falling edge and hold it until taken
    task automatic send_word(input item_t w, input logic fixed, input result_t want);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= w.action;
        s_tdata  <= {1'b0, w.cmd_mode, w.cmd_armed, w.status_armed, w.status_connected,
                     w.status_offboard, w.arm_on};
        do @(posedge aclk); while (!s_tready);
        predicted = supervise(w);
        pending_results.push_back(fixed ? want : predicted);
        @(negedge aclk);
    endtask

    int burst_left = 0;

    // Send in bursts with random gaps between them
    task automatic offer(input item_t w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
        burst_left--;
        send_word(w, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        if (idx == REG_CMD_TIMEOUT)
            cmd_limit = val;
        else
            stat_limit = val;
    endtask

    // Drain the block, let it settle, then load both timeouts
    task automatic set_timeouts(input logic [15:0] cmd_to, input logic [15:0] stat_to);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(REG_CMD_TIMEOUT, cmd_to);
        write_reg(REG_STAT_TIMEOUT, stat_to);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Stimulus
    initial begin
        logic [15:0] cmd_to;
        logic [15:0] stat_to;
        int          sent;
        int          run;
        sup_mode     = MODE_OFF;
        sup_cmd_mode = CMD_OTHER;
        cmd_age      = AGE_SAT;
        stat_age     = AGE_SAT;
        link_up      = 1'b0;
        fc_armed     = 1'b0;
        fc_offboard  = 1'b0;
        cmd_limit    = TIMEOUT_RESET;
        stat_limit   = TIMEOUT_RESET;

        // Directed walk from reset; fixed rows carry their known result
        add_row(make_word(ACT_TICK, 0, 0, 0, 0, 0, CMD_OTHER), 1'b1,
                make_result(MODE_OFF, FB_NONE, REF_NONE, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_ARM, 1, 0, 0, 0, 0, CMD_OTHER), 1'b1,
                make_result(MODE_OFF, FB_NONE, REF_CMD_TIMEOUT, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_CMD, 0, 0, 0, 0, 1, CMD_RATE), 1'b1,
                make_result(MODE_OFF, FB_NONE, REF_LOCKED, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_CMD, 0, 0, 0, 0, 0, CMD_ATT), 1'b1,
                make_result(MODE_OFF, FB_NONE, REF_NONE, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_ARM, 1, 0, 0, 0, 0, CMD_OTHER), 1'b1,
                make_result(MODE_OFF, FB_NONE, REF_LINK, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_STATUS, 0, 1, 1, 0, 0, CMD_OTHER), 1'b1,
                make_result(MODE_OFF, FB_NONE, REF_NONE, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_ARM, 1, 0, 0, 0, 0, CMD_OTHER), 1'b1,
                make_result(MODE_AUTO, FB_NONE, REF_NONE, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_CMD, 0, 0, 0, 0, 1, CMD_ATT), 1'b0, '0);
        add_row(make_word(ACT_CMD, 0, 0, 0, 0, 1, CMD_RATE), 1'b0, '0);
        add_row(make_word(ACT_STATUS, 0, 0, 1, 1, 0, CMD_OTHER), 1'b0, '0);
        add_row(make_word(ACT_CMD, 0, 0, 0, 0, 1, 2'b11), 1'b0, '0);
        add_row(make_word(ACT_STATUS, 0, 1, 1, 1, 0, CMD_OTHER), 1'b0, '0);
        add_row(make_word(ACT_CMD, 0, 0, 0, 0, 0, CMD_ATT), 1'b0, '0);
        add_row(make_word(ACT_CMD, 0, 0, 0, 0, 1, CMD_OTHER), 1'b0, '0);
        add_row(make_word(ACT_ARM, 0, 1, 1, 1, 1, 2'b11), 1'b1,
                make_result(MODE_OFF, FB_NONE, REF_NONE, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_ARM, 1, 0, 0, 0, 0, CMD_OTHER), 1'b0, '0);
        add_row(make_word(ACT_STATUS, 0, 1, 0, 1, 0, CMD_OTHER), 1'b0, '0);
        add_row(make_word(ACT_TICK, 1, 1, 1, 1, 1, 2'b11), 1'b0, '0);
        add_row(make_word(ACT_ARM, 1, 0, 0, 0, 0, CMD_OTHER), 1'b1,
                make_result(MODE_OFF, FB_NONE, REF_LINK, 1'b0, KIND_ZERO, 1'b0));
        add_row(make_word(ACT_STATUS, 1, 1, 1, 1, 1, 2'b11), 1'b0, '0);
        add_row(make_word(ACT_ARM, 1, 1, 1, 1, 1, 2'b11), 1'b0, '0);
        add_row(make_word(ACT_CMD, 0, 0, 0, 0, 1, CMD_RATE), 1'b0, '0);
        add_row(make_word(ACT_STATUS, 0, 0, 1, 1, 0, CMD_OTHER), 1'b0, '0);
        add_row(make_word(ACT_ARM, 1, 0, 0, 0, 0, CMD_OTHER), 1'b0, '0);
        add_row(make_word(ACT_STATUS, 0, 0, 0, 0, 0, CMD_OTHER), 1'b0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) send_word(plan[i].word, plan[i].fixed, plan[i].want);

        // Random phases, each under its own pair of timeouts
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin cmd_to = TIMEOUT_RESET; stat_to = TIMEOUT_RESET; end
                1: begin cmd_to = 16'd0;         stat_to = 16'd0;         end
                2: begin cmd_to = 16'hFFFF;      stat_to = 16'hFFFF;      end
                3: begin cmd_to = 16'd3;         stat_to = 16'd7;         end
                4: begin cmd_to = 16'd12;        stat_to = 16'd2;         end
                default: begin
                    cmd_to  = 16'($urandom_range(0, 20));
                    stat_to = 16'($urandom_range(0, 20));
                end
            endcase
            if (phase != 0) set_timeouts(cmd_to, stat_to);
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                // Occasional long tick runs can push the ages past the timeouts
                if ($urandom_range(0, 99) < 3) begin
                    run = $urandom_range(20, 70);
                    repeat (run) offer(make_word(ACT_TICK, 1'($urandom), 1'($urandom),
                                                 1'($urandom), 1'($urandom), 1'($urandom),
                                                 2'($urandom)));
                    sent += run;
                end else begin
                    offer(random_word());
                    sent++;
                end
            end
        end

        // Drain and settle
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side: check at the rising edge, steer ready at the falling edge
    initial begin
        result_t want;
        result_t got;
        int      seg_mode;
        int      seg_left;
        int      hold_left;
        seg_mode  = 0;
        seg_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.bridge_mode    = m_tdata[1:0];
                got.feedback_mode  = m_tdata[3:2];
                got.refusal        = m_tdata[5:4];
                got.setpoint_sent  = m_tdata[6];
                got.setpoint_kind  = m_tdata[8:7];
                got.arm_controller = m_tdata[9];
                if (pending_results.size() == 0) begin
                    $error("result word with no expectation pending: %h", m_tdata);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.bridge_mode != want.bridge_mode) begin
                        $error("bridge_mode: expected %0d, got %0d",
                               want.bridge_mode, got.bridge_mode);
                        errors++;
                    end
                    if (got.feedback_mode != want.feedback_mode) begin
                        $error("feedback_mode: expected %0d, got %0d",
                               want.feedback_mode, got.feedback_mode);
                        errors++;
                    end
                    if (got.refusal != want.refusal) begin
                        $error("refusal: expected %0d, got %0d", want.refusal, got.refusal);
                        errors++;
                    end
                    if (got.setpoint_sent != want.setpoint_sent) begin
                        $error("setpoint_sent: expected %0d, got %0d",
                               want.setpoint_sent, got.setpoint_sent);
                        errors++;
                    end
                    if (got.setpoint_kind != want.setpoint_kind) begin
                        $error("setpoint_kind: expected %0d, got %0d",
                               want.setpoint_kind, got.setpoint_kind);
                        errors++;
                    end
                    if (got.arm_controller != want.arm_controller) begin
                        $error("arm_controller: expected %0d, got %0d",
                               want.arm_controller, got.arm_controller);
                        errors++;
                    end
                end
                checked++;
                // Hold off long enough for the block to back up into its input
                if (checked == 200 || checked == 500) hold_left = LONG_HOLD_CYCLES;
            end

            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 64);
                end
                seg_left--;
                case (seg_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (seg_left % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/core/flas_pkg.sv
rtl/core/flas_in_reg.sv
rtl/core/flas_core.sv
rtl/core/flight_link_arming_supervisor.sv
tb/tb_flight_link_arming_supervisor.sv
